@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the partition allocator.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fpa_pkg.sv @@
// Package for the fixed-partition allocator: table sizes, field widths and codes.
// No dependencies; imported by fixed_partition_allocator_top.
package fpa_pkg;

  // Table geometry.
  localparam int BLOCKS    = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W     = $clog2(BLOCKS + 1);

  // Statistic widths.
  localparam int SUM_W     = 20;
  localparam int REFUSED_W = 16;

  // Item actions.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_ALLOC  = 2'd2;

  // Placement policies; the unused code behaves as first fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;

  // Result status.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

endpackage

@@ rtl/fixed_partition_allocator_top.sv @@
// Fixed-partition allocator with first, best and next fit placement.
// Depends on fpa_pkg and assert_macros.svh.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   in_action, in_size_value
//   out_      output     out_valid / out_stall granted, index, waste, statistics
//   cfg_      input      cfg_wr_en             cfg_wr_data (fit policy)
//
// An allocate request scans the table one block per cycle through a single
// size comparator, in the order accept, scan and commit. First and next fit
// stop at the first hit. Clear, append and unused actions go from accept
// straight to commit without a scan.
// Reset clears the table, all statistics and the policy; sizes are not cleared.
// A stalled result stays in the output register; the next request is accepted,
// and its commit waits until the output register is free.
module fixed_partition_allocator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [fpa_pkg::SIZE_BITS-1:0]    in_size_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_granted,
  output logic [fpa_pkg::IDX_W-1:0]        out_block_index,
  output logic [fpa_pkg::SIZE_BITS-1:0]    out_internal_waste,
  output logic [fpa_pkg::REFUSED_W-1:0]    out_unallocated_count,
  output logic [fpa_pkg::SUM_W-1:0]        out_internal_total,
  output logic [fpa_pkg::SUM_W-1:0]        out_external_total,
  output logic [fpa_pkg::CNT_W-1:0]        out_blocks_stored,
  output logic                             out_status,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_wr_data
);
  import fpa_pkg::*;
  `include "assert_macros.svh"

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [1:0]             policy_r;
  logic [1:0]             action_r, action_nxt;
  logic [SIZE_BITS-1:0]   req_r, req_nxt;

  // Partition table.
  logic [SIZE_BITS-1:0]   size_mem [BLOCKS];
  logic [SIZE_BITS-1:0]   rd_size_r;
  logic [BLOCKS-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;

  // Run statistics.
  logic [SUM_W-1:0]       free_r, free_nxt;
  logic [SUM_W-1:0]       waste_sum_r, waste_sum_nxt;
  logic [REFUSED_W-1:0]   refused_r, refused_nxt;

  // Scan state.
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic [IDX_W-1:0]       step_r, step_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       pick_idx_r, pick_idx_nxt;
  logic [SIZE_BITS-1:0]   pick_size_r, pick_size_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic                   granted_r, granted_nxt;
  logic [IDX_W-1:0]       index_r, index_nxt;
  logic [SIZE_BITS-1:0]   waste_r, waste_nxt;
  logic                   status_r, status_nxt;

  // Shared comparator and scan helpers.
  logic                   in_take;
  logic                   out_take;
  logic                   out_busy;
  logic [SIZE_BITS-1:0]   cur_size;
  logic                   hit;
  logic                   better;
  logic                   last_step;
  logic [IDX_W-1:0]       pos_adv;
  logic [IDX_W-1:0]       start_pos;
  logic                   do_append;
  logic [SUM_W:0]         free_add;
  logic [SUM_W:0]         waste_add;
  logic [SIZE_BITS-1:0]   grant_waste;
  logic [SUM_W-1:0]       pick_ext;

  // Terms used by the checks.
  logic                   scan_in_range;
  logic                   refused_out;
  logic                   no_block;
  logic                   commit_go;
  logic                   result_loaded;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_busy  = out_valid_r && out_stall;

  // One table entry per cycle goes through the fit comparator.
  assign cur_size  = rd_size_r;
  assign hit       = !used_r[pos_r] && (cur_size >= req_r);
  assign better    = !found_r || (cur_size < pick_size_r);
  assign last_step = ((CNT_W'(step_r) + CNT_W'(1)) == total_r);
  assign pos_adv   = ((CNT_W'(pos_r) + CNT_W'(1)) == total_r) ? '0 : pos_r + IDX_W'(1);
  assign start_pos = ((policy_r == POL_NEXT) && (CNT_W'(ptr_r) < total_r)) ? ptr_r : '0;

  // Commit arithmetic.
  assign do_append   = (state_r == S_COMMIT) && !out_busy && (action_r == ACT_APPEND) &&
                       (total_r < CNT_W'(BLOCKS));
  assign grant_waste = pick_size_r - req_r;
  assign pick_ext    = SUM_W'(pick_size_r);
  assign free_add    = {1'b0, free_r} + (SUM_W + 1)'(req_r);
  assign waste_add   = {1'b0, waste_sum_r} + (SUM_W + 1)'(grant_waste);

  // Sequencer and state updates.
  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    req_nxt       = req_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    ptr_nxt       = ptr_r;
    free_nxt      = free_r;
    waste_sum_nxt = waste_sum_r;
    refused_nxt   = refused_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    pick_idx_nxt  = pick_idx_r;
    pick_size_nxt = pick_size_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    granted_nxt   = granted_r;
    index_nxt     = index_r;
    waste_nxt     = waste_r;
    status_nxt    = status_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          action_nxt = in_action;
          req_nxt    = in_size_value;
          pos_nxt    = start_pos;
          step_nxt   = '0;
          found_nxt  = 1'b0;
          if ((in_action == ACT_ALLOC) && (total_r != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_SCAN: begin
        pos_nxt  = pos_adv;
        step_nxt = step_r + IDX_W'(1);
        if (policy_r == POL_BEST) begin
          if (hit && better) begin
            found_nxt     = 1'b1;
            pick_idx_nxt  = pos_r;
            pick_size_nxt = cur_size;
          end
          if (last_step) begin
            state_nxt = S_COMMIT;
          end
        end else begin
          if (hit) begin
            found_nxt     = 1'b1;
            pick_idx_nxt  = pos_r;
            pick_size_nxt = cur_size;
            state_nxt     = S_COMMIT;
          end else if (last_step) begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        if (!out_busy) begin
          granted_nxt = 1'b0;
          index_nxt   = '0;
          waste_nxt   = '0;
          status_nxt  = STAT_OK;
          case (action_r)
            ACT_CLEAR: begin
              used_nxt      = '0;
              total_nxt     = '0;
              ptr_nxt       = '0;
              free_nxt      = '0;
              waste_sum_nxt = '0;
              refused_nxt   = '0;
            end
            ACT_APPEND: begin
              if (total_r < CNT_W'(BLOCKS)) begin
                used_nxt[total_r[IDX_W-1:0]] = 1'b0;
                total_nxt = total_r + CNT_W'(1);
                free_nxt  = free_add[SUM_W] ? {SUM_W{1'b1}} : free_add[SUM_W-1:0];
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            ACT_ALLOC: begin
              if (found_r) begin
                granted_nxt            = 1'b1;
                index_nxt              = pick_idx_r;
                waste_nxt              = grant_waste;
                used_nxt[pick_idx_r]   = 1'b1;
                free_nxt      = (free_r >= pick_ext) ? free_r - pick_ext : '0;
                waste_sum_nxt = waste_add[SUM_W] ? {SUM_W{1'b1}} : waste_add[SUM_W-1:0];
                ptr_nxt       = ((CNT_W'(pick_idx_r) + CNT_W'(1)) >= total_r) ?
                                '0 : pick_idx_r + IDX_W'(1);
              end else if (refused_r != {REFUSED_W{1'b1}}) begin
                refused_nxt = refused_r + REFUSED_W'(1);
              end
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIRST;
      used_r      <= '0;
      total_r     <= '0;
      ptr_r       <= '0;
      free_r      <= '0;
      waste_sum_r <= '0;
      refused_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      ptr_r       <= ptr_nxt;
      free_r      <= free_nxt;
      waste_sum_r <= waste_sum_nxt;
      refused_r   <= refused_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    req_r       <= req_nxt;
    pos_r       <= pos_nxt;
    step_r      <= step_nxt;
    found_r     <= found_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_size_r <= pick_size_nxt;
    granted_r   <= granted_nxt;
    index_r     <= index_nxt;
    waste_r     <= waste_nxt;
    status_r    <= status_nxt;
  end

  // Partition size table, written on append; the read follows the scan position
  // so the entry at pos_r is in rd_size_r during each scan cycle.
  always_ff @(posedge clk) begin
    if (do_append) begin
      size_mem[total_r[IDX_W-1:0]] <= req_r;
    end
    rd_size_r <= size_mem[pos_nxt];
  end

  // Result ports.
  assign out_valid             = out_valid_r;
  assign out_granted           = granted_r;
  assign out_block_index       = index_r;
  assign out_internal_waste    = waste_r;
  assign out_unallocated_count = refused_r;
  assign out_internal_total    = waste_sum_r;
  assign out_external_total    = free_r;
  assign out_blocks_stored     = total_r;
  assign out_status            = status_r;

  // Checks on the sequencer and the result contents.
  assign scan_in_range = (CNT_W'(step_r) < total_r);
  assign refused_out   = out_valid && !out_granted;
  assign no_block      = (out_block_index == '0) && (out_internal_waste == '0);
  assign commit_go     = (state_r == S_COMMIT) && !out_busy;
  assign result_loaded = out_valid_r && (state_r == S_IDLE);

  `FPA_ASSERT(a_total_bound, total_r <= CNT_W'(BLOCKS), "table count exceeds capacity")
  `FPA_ASSERT(a_scan_bound, (state_r == S_SCAN) |-> scan_in_range, "scan past table end")
  `FPA_ASSERT(a_refused_fields, refused_out |-> no_block, "refused result carries a block")
  `FPA_ASSERT_NEXT(a_commit_loads, commit_go, result_loaded, "commit did not load the result")

endmodule
